/* src/tccw_pkg.sv */
`timescale 1ns / 1ps
// tccw_pkg: shared types and constants for the text console character writer
// no dependencies

package tccw_pkg;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ADDR_W = 11;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_NUL       = 8'd0;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_CLEAR = 5'b00100,
    ST_INIT  = 5'b01000,
    ST_READ  = 5'b10000
  } state_t;

endpackage

/* src/tccw_ram.sv */
`timescale 1ns / 1ps
// tccw_ram: generic single-port ram with registered read data
// no dependencies

module tccw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1680
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* src/text_console_char_writer_core.sv */
`timescale 1ns / 1ps
// text_console_char_writer_core: circular character store with cursor control
// depends on tccw_pkg and tccw_ram
//
// channel | valid       | stall        | fields
// item    | item_valid  | item_stall   | kind, character, read_address
// result  | result_valid| result_stall | cursor, read_data, return_pending
//
// printable, return, backspace, null and unused kind finish from ST_IDLE, a read goes via ST_READ
// newline writes up to COLUMNS cells and tab up to TAB_STOP, one cell per cycle
// clear writes all COLUMNS*ROWS cells, all bound by the single store write port
// after reset a clearing pass of COLUMNS*ROWS cells runs before the first beat
// a new item is taken only when the result register is empty or being drained

module text_console_char_writer_core
  import tccw_pkg::*;
#(
  parameter int unsigned COLUMNS  = 80,
  parameter int unsigned ROWS     = 21,
  parameter int unsigned TAB_STOP = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [KIND_W-1:0] kind,
  input  logic [CHAR_W-1:0] character,
  input  logic [ADDR_W-1:0] read_address,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [ADDR_W-1:0] cursor,
  output logic [CHAR_W-1:0] read_data,
  output logic              return_pending
);

  localparam int unsigned STORE = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(STORE);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned TW    = $clog2(TAB_STOP);

  state_t          state, state_next;
  logic [AW-1:0]   cur, cur_next;
  logic [CW-1:0]   col, col_next;
  logic [TW-1:0]   colmod, colmod_next;
  logic [TW-1:0]   tabpos, tabpos_next;
  logic            ret_flag, ret_flag_next;
  logic [AW-1:0]   clr_cnt, clr_cnt_next;
  logic            pad_tab, pad_tab_next;
  logic            rd_ok, rd_ok_next;
  logic            load;
  logic [CHAR_W-1:0] read_data_next;

  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [CHAR_W-1:0] ram_rdata;

  logic            accept;
  logic            is_print;
  logic            use_ls;
  logic [AW-1:0]   ls_cur;
  logic [TW:0]     ls_tab_sum;
  logic [TW-1:0]   ls_tab;
  logic [AW-1:0]   base_cur;
  logic [CW-1:0]   base_col;
  logic [TW-1:0]   base_colmod;
  logic [TW-1:0]   base_tab;
  logic [AW-1:0]   adv_cur;
  logic [CW-1:0]   adv_col;
  logic [TW-1:0]   adv_colmod;
  logic [TW-1:0]   adv_tab;
  logic [AW+ADDR_W-1:0] addr_ext;
  logic [AW+ADDR_W-1:0] cur_ext;

  tccw_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(STORE)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign item_stall = !((state == ST_IDLE) && (!result_valid || !result_stall));
  assign accept     = item_valid && !item_stall;

  assign cur_ext        = {{ADDR_W{1'b0}}, cur};
  assign cursor         = cur_ext[ADDR_W-1:0];
  assign return_pending = ret_flag;
  assign addr_ext       = {{AW{1'b0}}, read_address};

  assign is_print = (character != CH_NUL) && (character != CH_NEWLINE) &&
                    (character != CH_TAB) && (character != CH_BACKSPACE) &&
                    (character != CH_RETURN);

  // line start and its position within the tab grid
  assign ls_cur     = cur - AW'(col);
  assign ls_tab_sum = (tabpos >= colmod) ? ({1'b0, tabpos} - {1'b0, colmod})
                                         : ({1'b0, tabpos} + (TW + 1)'(TAB_STOP)
                                            - {1'b0, colmod});
  assign ls_tab     = ls_tab_sum[TW-1:0];

  assign use_ls      = (state == ST_IDLE) && ret_flag && is_print;
  assign base_cur    = use_ls ? ls_cur : cur;
  assign base_col    = use_ls ? '0 : col;
  assign base_colmod = use_ls ? '0 : colmod;
  assign base_tab    = use_ls ? ls_tab : tabpos;

  // shared cursor advance unit
  assign adv_cur    = (base_cur == AW'(STORE - 1)) ? '0 : base_cur + 1'b1;
  assign adv_col    = (base_col == CW'(COLUMNS - 1)) ? '0 : base_col + 1'b1;
  assign adv_colmod = ((base_col == CW'(COLUMNS - 1)) || (base_colmod == TW'(TAB_STOP - 1)))
                      ? '0 : base_colmod + 1'b1;
  assign adv_tab    = ((base_cur == AW'(STORE - 1)) || (base_tab == TW'(TAB_STOP - 1)))
                      ? '0 : base_tab + 1'b1;

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    col_next       = col;
    colmod_next    = colmod;
    tabpos_next    = tabpos;
    ret_flag_next  = ret_flag;
    clr_cnt_next   = clr_cnt;
    pad_tab_next   = pad_tab;
    rd_ok_next     = rd_ok;
    load           = 1'b0;
    read_data_next = '0;
    ram_we         = 1'b0;
    ram_addr       = base_cur;
    ram_wdata      = CH_SPACE;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_WRITE: begin
              case (character)
                CH_NUL: begin
                  load = 1'b1;
                end
                CH_RETURN: begin
                  ret_flag_next = 1'b1;
                  load          = 1'b1;
                end
                CH_BACKSPACE: begin
                  if (col != '0) begin
                    cur_next    = cur - 1'b1;
                    col_next    = col - 1'b1;
                    colmod_next = (colmod == '0) ? TW'(TAB_STOP - 1) : colmod - 1'b1;
                    tabpos_next = (tabpos == '0) ? TW'(TAB_STOP - 1) : tabpos - 1'b1;
                    ram_we      = 1'b1;
                    ram_addr    = cur - 1'b1;
                  end
                  load = 1'b1;
                end
                CH_NEWLINE, CH_TAB: begin
                  ram_we        = 1'b1;
                  cur_next      = adv_cur;
                  col_next      = adv_col;
                  colmod_next   = adv_colmod;
                  tabpos_next   = adv_tab;
                  pad_tab_next  = (character == CH_TAB);
                  if (character == CH_NEWLINE) begin
                    ret_flag_next = 1'b0;
                  end
                  if (((character == CH_TAB) && (adv_tab == '0)) ||
                      ((character == CH_NEWLINE) && (adv_col == '0))) begin
                    load = 1'b1;
                  end else begin
                    state_next = ST_PAD;
                  end
                end
                default: begin
                  ram_we        = 1'b1;
                  ram_wdata     = character;
                  cur_next      = adv_cur;
                  col_next      = adv_col;
                  colmod_next   = adv_colmod;
                  tabpos_next   = adv_tab;
                  ret_flag_next = 1'b0;
                  load          = 1'b1;
                end
              endcase
            end
            KIND_CLEAR: begin
              clr_cnt_next = '0;
              state_next   = ST_CLEAR;
            end
            KIND_READ: begin
              ram_addr   = addr_ext[AW-1:0];
              rd_ok_next = (addr_ext < (AW + ADDR_W)'(STORE));
              state_next = ST_READ;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_PAD: begin
        ram_we      = 1'b1;
        cur_next    = adv_cur;
        col_next    = adv_col;
        colmod_next = adv_colmod;
        tabpos_next = adv_tab;
        if ((pad_tab && (adv_tab == '0)) || (!pad_tab && (adv_col == '0))) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR, ST_INIT: begin
        ram_we       = 1'b1;
        ram_addr     = clr_cnt;
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == AW'(STORE - 1)) begin
          load       = (state == ST_CLEAR);
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        read_data_next = rd_ok ? ram_rdata : '0;
        load           = 1'b1;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      cur          <= '0;
      col          <= '0;
      colmod       <= '0;
      tabpos       <= '0;
      ret_flag     <= 1'b0;
      clr_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      state    <= state_next;
      cur      <= cur_next;
      col      <= col_next;
      colmod   <= colmod_next;
      tabpos   <= tabpos_next;
      ret_flag <= ret_flag_next;
      clr_cnt  <= clr_cnt_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pad_tab <= pad_tab_next;
    rd_ok   <= rd_ok_next;
    if (load) begin
      read_data <= read_data_next;
    end
  end

endmodule
